### rtl/dot_star_pattern_matcher_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dot-star pattern matcher
// Concurrent property wrappers with a common clock and reset.
// ----------------------------------------------------------------------------
`ifndef DOT_STAR_PATTERN_MATCHER_MACROS_SVH
`define DOT_STAR_PATTERN_MATCHER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DSPM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DSPM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/dspm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dot-star pattern matcher package
// Transaction types, opcodes, command kinds and queue sizing.
// ----------------------------------------------------------------------------
package dspm_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_TEXT   = 2'd2;
    localparam logic [1:0] OP_END    = 2'd3;

    localparam logic [7:0] WILDCARD_BYTE = 8'd46;
    localparam logic [7:0] STAR_BYTE     = 8'd42;

    localparam logic [2:0] CMD_CLEAR   = 3'd0;
    localparam logic [2:0] CMD_LITERAL = 3'd1;
    localparam logic [2:0] CMD_STAR    = 3'd2;
    localparam logic [2:0] CMD_TEXT    = 3'd3;
    localparam logic [2:0] CMD_END     = 3'd4;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] symbol;
    } t_in;

    typedef struct packed {
        logic matched;
        logic pattern_fault;
    } t_out;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] symbol;
    } t_cmd;

    typedef struct packed {
        logic pop_end;
        logic pop_clear;
        logic fault;
    } t_back_stat;

endpackage

### rtl/dot_star_pattern_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dot-star pattern matcher
// Whole-string matcher for literal, wildcard and starred pattern elements.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid, o_in_stall, i_in_data): each transaction clears
// the pattern, appends a pattern byte, supplies a text byte or ends the text.
// Output channel (o_out_valid, i_out_stall, o_out_data): one transaction per
// end of text, carrying the match answer and the sticky pattern fault.
// The block takes one transaction per cycle while its queue has room.
// A transaction enters a four-entry command queue at acceptance and, with the
// queue otherwise empty, the engine executes it in the next cycle, unless it
// is an end of text waiting for a free output register. An end-of-text answer
// passes from the queue to the output register, where it waits for the
// receiver. The engine updates every pattern position at once, the closure
// being a single carry chain.
// After reset the pattern is empty, the fault is clear and the active vector
// holds position zero only. While the receiver stalls, the answer is held in
// the output register; the engine keeps executing the commands ahead of the
// next end of text, and the input stalls once the queue is full.
// ----------------------------------------------------------------------------
`include "dot_star_pattern_matcher_macros.svh"

module dot_star_pattern_matcher #(
    parameter int MAX_ELEMENTS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  dspm_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output dspm_pkg::t_out o_out_data
);

    logic                          w_push;
    dspm_pkg::t_cmd                w_front_cmd;
    logic                          w_fifo_full;
    logic                          w_fifo_valid;
    dspm_pkg::t_cmd                w_head_cmd;
    logic [dspm_pkg::FIFO_CW-1:0]  w_level;
    logic                          w_pop;
    dspm_pkg::t_back_stat          w_stat;

    dspm_front u_front (
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_fifo_full (w_fifo_full),
        .o_in_stall  (o_in_stall),
        .o_push      (w_push),
        .o_cmd       (w_front_cmd)
    );

    dspm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_valid (w_fifo_valid),
        .o_cmd   (w_head_cmd),
        .o_full  (w_fifo_full),
        .o_level (w_level)
    );

    dspm_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_fifo_valid),
        .i_cmd       (w_head_cmd),
        .i_out_stall (i_out_stall),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_stat      (w_stat)
    );

    `DSPM_ASSERT_IMP(a_queue_bound, i_clk, i_rst_n, 1'b1,
                     w_level <= dspm_pkg::FIFO_CW'(dspm_pkg::FIFO_DEPTH),
                     "command queue level beyond its depth")
    `DSPM_ASSERT_NXT(a_end_gives_result, i_clk, i_rst_n, w_stat.pop_end, o_out_valid,
                     "end of text did not give a result")
    `DSPM_ASSERT_NXT(a_clear_drops_fault, i_clk, i_rst_n, w_stat.pop_clear, !w_stat.fault,
                     "pattern clear left the fault set")

endmodule

### rtl/dspm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dot-star matcher front end
// Accepts input transactions and classifies them into engine commands.
// ----------------------------------------------------------------------------
module dspm_front (
    input  logic           i_in_valid,
    input  dspm_pkg::t_in  i_in_data,
    input  logic           i_fifo_full,
    output logic           o_in_stall,
    output logic           o_push,
    output dspm_pkg::t_cmd o_cmd
);

    always_comb begin
        o_cmd.symbol = i_in_data.symbol;
        case (i_in_data.opcode)
            dspm_pkg::OP_CLEAR: begin
                o_cmd.kind = dspm_pkg::CMD_CLEAR;
            end
            dspm_pkg::OP_APPEND: begin
                if (i_in_data.symbol == dspm_pkg::STAR_BYTE) begin
                    o_cmd.kind = dspm_pkg::CMD_STAR;
                end else begin
                    o_cmd.kind = dspm_pkg::CMD_LITERAL;
                end
            end
            dspm_pkg::OP_TEXT: begin
                o_cmd.kind = dspm_pkg::CMD_TEXT;
            end
            default: begin
                o_cmd.kind = dspm_pkg::CMD_END;
            end
        endcase
    end

    assign o_in_stall = i_fifo_full;
    assign o_push     = i_in_valid && !i_fifo_full;

endmodule

### rtl/dspm_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dot-star matcher command queue
// Short first-in first-out queue between the front end and the engine.
// ----------------------------------------------------------------------------
module dspm_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  dspm_pkg::t_cmd              i_cmd,
    input  logic                        i_pop,
    output logic                        o_valid,
    output dspm_pkg::t_cmd              o_cmd,
    output logic                        o_full,
    output logic [dspm_pkg::FIFO_CW-1:0] o_level
);

    dspm_pkg::t_cmd                r_mem [dspm_pkg::FIFO_DEPTH];
    logic [dspm_pkg::FIFO_AW-1:0]  r_wr;
    logic [dspm_pkg::FIFO_AW-1:0]  r_rd;
    logic [dspm_pkg::FIFO_CW-1:0]  r_level;
    logic [dspm_pkg::FIFO_CW-1:0]  n_level;

    always_comb begin
        n_level = r_level;
        if (i_push && !i_pop) begin
            n_level = r_level + dspm_pkg::FIFO_CW'(1);
        end else if (!i_push && i_pop) begin
            n_level = r_level - dspm_pkg::FIFO_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + dspm_pkg::FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + dspm_pkg::FIFO_AW'(1);
            end
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_valid = (r_level != '0);
    assign o_cmd   = r_mem[r_rd];
    assign o_full  = (r_level == dspm_pkg::FIFO_CW'(dspm_pkg::FIFO_DEPTH));
    assign o_level = r_level;

endmodule

### rtl/dspm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dot-star matcher engine
// Holds the pattern and advances the active position vector per command.
// ----------------------------------------------------------------------------
module dspm_back #(
    parameter int MAX_ELEMENTS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  dspm_pkg::t_cmd       i_cmd,
    input  logic                 i_out_stall,
    output logic                 o_pop,
    output logic                 o_out_valid,
    output dspm_pkg::t_out       o_out_data,
    output dspm_pkg::t_back_stat o_stat
);

    localparam int VW = MAX_ELEMENTS + 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int IW = $clog2(MAX_ELEMENTS);

    logic [7:0]              r_byte [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0] r_star;
    logic [MAX_ELEMENTS-1:0] r_fill;
    logic [CW-1:0]           r_count;
    logic [VW-1:0]           r_active;
    logic                    r_fault;
    logic                    r_last_star;
    logic                    r_out_valid;
    dspm_pkg::t_out          r_out;

    logic [MAX_ELEMENTS-1:0] n_fill;
    logic [CW-1:0]           n_count;
    logic [VW-1:0]           n_active;
    logic                    n_fault;
    logic                    n_last_star;

    logic [MAX_ELEMENTS-1:0] w_prop;
    logic [MAX_ELEMENTS-1:0] w_hit;
    logic [VW-1:0]           w_q;
    logic [VW:0]             w_a;
    logic [VW:0]             w_b;
    logic [VW:0]             w_sum;
    logic [VW:0]             w_carry;
    logic [VW-1:0]           w_closed;
    logic [VW-1:0]           w_next;
    logic                    w_full;
    logic                    w_empty;
    logic                    w_out_free;
    logic [IW-1:0]           w_wr_idx;
    logic [IW-1:0]           w_last_idx;
    logic                    w_wr_lit;
    logic                    w_wr_star;

    // The closure ripple is a carry chain: generate is the active bit and
    // propagate is a starred element below the position.
    assign w_prop   = r_star & r_fill;
    assign w_q      = {w_prop, 1'b0};
    assign w_a      = {1'b0, r_active | w_q};
    assign w_b      = {1'b0, r_active};
    assign w_sum    = w_a + w_b;
    assign w_carry  = w_sum ^ w_a ^ w_b;
    assign w_closed = w_carry[VW:1];

    always_comb begin
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
            w_hit[i] = r_fill[i] && w_closed[i] &&
                       ((r_byte[i] == dspm_pkg::WILDCARD_BYTE) ||
                        (r_byte[i] == i_cmd.symbol));
        end
    end

    assign w_next = {1'b0, w_hit & r_star} | {w_hit & ~r_star, 1'b0};

    assign w_full     = (r_count == CW'(MAX_ELEMENTS));
    assign w_empty    = (r_count == '0);
    assign w_wr_idx   = r_count[IW-1:0];
    assign w_last_idx = IW'(r_count - CW'(1));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_pop      = i_cmd_valid && ((i_cmd.kind != dspm_pkg::CMD_END) || w_out_free);
    assign w_wr_lit   = o_pop && (i_cmd.kind == dspm_pkg::CMD_LITERAL) && !w_full;
    assign w_wr_star  = o_pop && (i_cmd.kind == dspm_pkg::CMD_STAR) &&
                        !w_empty && !r_last_star;

    always_comb begin
        n_fill      = r_fill;
        n_count     = r_count;
        n_active    = r_active;
        n_fault     = r_fault;
        n_last_star = r_last_star;
        if (o_pop) begin
            case (i_cmd.kind)
                dspm_pkg::CMD_CLEAR: begin
                    n_fill      = '0;
                    n_count     = '0;
                    n_fault     = 1'b0;
                    n_last_star = 1'b0;
                    n_active    = VW'(1);
                end
                dspm_pkg::CMD_LITERAL: begin
                    n_active = VW'(1);
                    if (w_full) begin
                        n_fault = 1'b1;
                    end else begin
                        n_fill[w_wr_idx] = 1'b1;
                        n_count          = r_count + CW'(1);
                        n_last_star      = 1'b0;
                    end
                end
                dspm_pkg::CMD_STAR: begin
                    n_active = VW'(1);
                    if (w_empty || r_last_star) begin
                        n_fault = 1'b1;
                    end else begin
                        n_last_star = 1'b1;
                    end
                end
                dspm_pkg::CMD_TEXT: begin
                    n_active = w_next;
                end
                default: begin
                    n_active = VW'(1);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_count     <= '0;
            r_active    <= VW'(1);
            r_fault     <= 1'b0;
            r_last_star <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_count     <= n_count;
            r_active    <= n_active;
            r_fault     <= n_fault;
            r_last_star <= n_last_star;
            if (o_pop && (i_cmd.kind == dspm_pkg::CMD_END)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_lit) begin
            r_byte[w_wr_idx] <= i_cmd.symbol;
            r_star[w_wr_idx] <= 1'b0;
        end
        if (w_wr_star) begin
            r_star[w_last_idx] <= 1'b1;
        end
        if (o_pop && (i_cmd.kind == dspm_pkg::CMD_END)) begin
            r_out.matched       <= w_closed[r_count] && !r_fault;
            r_out.pattern_fault <= r_fault;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out;
    assign o_stat.pop_end   = o_pop && (i_cmd.kind == dspm_pkg::CMD_END);
    assign o_stat.pop_clear = o_pop && (i_cmd.kind == dspm_pkg::CMD_CLEAR);
    assign o_stat.fault     = r_fault;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the dot-star pattern matcher
// A short table of directed transactions covers the empty pattern, stray and
// double stars, store overflow, wildcards and trailing starred elements. A
// long random run of pattern loads and texts follows, most of them built to
// match, with noise mixed in. Every end-of-text answer is checked against a
// bit-level predictor, or against the table for the pinned directed rows. The
// input idles and the receiver stalls at random, and the receiver holds off
// once for long enough to fill the block and stall its input.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAX_EL       = 32;
    localparam int RANDOM_ITEMS = 650;
    localparam int LIMIT        = 200000;
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 10;
    localparam int REPORT_LIMIT = 10;
    localparam int N_ROWS       = 34;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] symbol;
        logic [5:0] reps;
        logic       pinned;
        logic       matched;
        logic       fault;
    } t_dir_row;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    dspm_pkg::t_in  in_data;
    logic           out_valid;
    logic           out_stall;
    dspm_pkg::t_out out_data;

    logic [8:0]      pat_elem [MAX_EL];
    int unsigned     pat_len;
    logic [MAX_EL:0] live_pos;
    logic            pat_fault;

    dspm_pkg::t_out answer_queue [$];
    dspm_pkg::t_out oldest;
    t_dir_row       dir_rows [N_ROWS];
    int             items_sent;
    int             answers_checked;
    int             matches_seen;
    int             faults_seen;
    int             fail_count;
    int             cycle_count;
    bit             no_idle;
    bit             hold_request;
    bit             hold_issued;

    dot_star_pattern_matcher #(.MAX_ELEMENTS(MAX_EL)) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #10 clk = ~clk;

    // Starred positions that are live also make the position after them live.
    function automatic void live_close();
        for (int i = 0; i < pat_len; i++) begin
            if (live_pos[i] && pat_elem[i][8]) begin
                live_pos[i + 1] = 1'b1;
            end
        end
    endfunction

    function automatic void live_advance(input logic [7:0] sym);
        logic [MAX_EL:0] nxt;
        nxt = '0;
        live_close();
        for (int i = 0; i < pat_len; i++) begin
            if (live_pos[i] && (pat_elem[i][7:0] == dspm_pkg::WILDCARD_BYTE ||
                                pat_elem[i][7:0] == sym)) begin
                if (pat_elem[i][8]) begin
                    nxt[i] = 1'b1;
                end else begin
                    nxt[i + 1] = 1'b1;
                end
            end
        end
        live_pos = nxt;
    endfunction

    function automatic void pattern_append(input logic [7:0] sym);
        live_pos = {{MAX_EL{1'b0}}, 1'b1};
        if (sym == dspm_pkg::STAR_BYTE) begin
            if (pat_len == 0 || pat_elem[pat_len - 1][8]) begin
                pat_fault = 1'b1;
            end else begin
                pat_elem[pat_len - 1][8] = 1'b1;
            end
        end else if (pat_len >= MAX_EL) begin
            pat_fault = 1'b1;
        end else begin
            pat_elem[pat_len] = {1'b0, sym};
            pat_len++;
        end
    endfunction

    function automatic bit matcher_step(input dspm_pkg::t_in item,
                                        output dspm_pkg::t_out answer);
        answer = '0;
        matcher_step = 1'b0;
        case (item.opcode)
            dspm_pkg::OP_CLEAR: begin
                pat_len   = 0;
                pat_fault = 1'b0;
                live_pos  = {{MAX_EL{1'b0}}, 1'b1};
            end
            dspm_pkg::OP_APPEND: begin
                pattern_append(item.symbol);
            end
            dspm_pkg::OP_TEXT: begin
                live_advance(item.symbol);
            end
            default: begin
                live_close();
                answer.matched       = live_pos[pat_len] && !pat_fault;
                answer.pattern_fault = pat_fault;
                live_pos             = {{MAX_EL{1'b0}}, 1'b1};
                matcher_step         = 1'b1;
            end
        endcase
    endfunction

    function automatic void log_failure(input string what, input dspm_pkg::t_out want,
                                        input dspm_pkg::t_out got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("[%0t] %s: expected matched=%0b fault=%0b, got matched=%0b fault=%0b",
                     $time, what, want.matched, want.pattern_fault,
                     got.matched, got.pattern_fault);
        end
    endfunction

    function automatic logic [7:0] pick_byte(input bit allow_wild);
        int r;
        r = $urandom_range(0, 9);
        if (r == 9) begin
            return 8'($urandom_range(0, 255));
        end else if (allow_wild && r < 2) begin
            return dspm_pkg::WILDCARD_BYTE;
        end
        return 8'h61 + 8'($urandom_range(0, 2));
    endfunction

    task automatic send(input dspm_pkg::t_in item, input bit pinned,
                        input dspm_pkg::t_out pinned_answer);
        int             gap;
        dspm_pkg::t_out answer;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= item;
        do begin
            @(posedge clk);
        end while (in_stall);
        items_sent++;
        if (matcher_step(item, answer)) begin
            answer_queue.push_back(pinned ? pinned_answer : answer);
        end
    endtask

    task automatic send_op(input logic [1:0] op, input logic [7:0] sym);
        send('{opcode: op, symbol: sym}, 1'b0, '0);
    endtask

    task automatic random_sequence();
        logic [7:0] el_sym [40];
        bit         el_star [40];
        logic [7:0] txt [$];
        int         n_el;
        int         reps;
        int         k;
        if ($urandom_range(0, 99) < 85) begin
            send_op(dspm_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
            n_el = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 34) : $urandom_range(0, 6);
            for (int i = 0; i < n_el; i++) begin
                el_sym[i]  = pick_byte(1'b1);
                el_star[i] = ($urandom_range(0, 2) == 0);
                send_op(dspm_pkg::OP_APPEND, el_sym[i]);
                if (el_star[i]) begin
                    send_op(dspm_pkg::OP_APPEND, dspm_pkg::STAR_BYTE);
                end
                if ($urandom_range(0, 29) == 0) begin
                    send_op(dspm_pkg::OP_APPEND, dspm_pkg::STAR_BYTE);
                    el_star[i] = 1'b1;
                end
            end
            repeat ($urandom_range(1, 3)) begin
                txt.delete();
                for (int i = 0; i < n_el && i < MAX_EL; i++) begin
                    reps = el_star[i] ? $urandom_range(0, 3) : 1;
                    repeat (reps) begin
                        txt.push_back(el_sym[i] == dspm_pkg::WILDCARD_BYTE ?
                                      pick_byte(1'b0) : el_sym[i]);
                    end
                end
                if ($urandom_range(0, 3) == 0) begin
                    if (txt.size() > 0 && $urandom_range(0, 1) == 0) begin
                        k = $urandom_range(0, txt.size() - 1);
                        txt[k] = pick_byte(1'b0);
                    end else begin
                        txt.push_back(pick_byte(1'b0));
                    end
                end
                foreach (txt[i]) begin
                    send_op(dspm_pkg::OP_TEXT, txt[i]);
                end
                send_op(dspm_pkg::OP_END, 8'($urandom_range(0, 255)));
            end
        end else begin
            repeat ($urandom_range(1, 8)) begin
                send_op(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Receiver: a random stall before each result, and one long hold-off.
    initial begin
        int wait_cycles;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            wait_cycles = no_idle ? 0 : $urandom_range(0, 3);
            if (hold_request) begin
                wait_cycles  = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (wait_cycles > 0) begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (wait_cycles - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do begin
                @(posedge clk);
            end while (!out_valid);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (answer_queue.size() == 0) begin
                log_failure("answer with nothing expected", '0, out_data);
            end else begin
                oldest = answer_queue.pop_front();
                answers_checked++;
                if (out_data.matched !== oldest.matched ||
                    out_data.pattern_fault !== oldest.pattern_fault) begin
                    log_failure("answer mismatch", oldest, out_data);
                end
            end
            if (out_data.matched === 1'b1) begin
                matches_seen++;
            end
            if (out_data.pattern_fault === 1'b1) begin
                faults_seen++;
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run exceeded %0d cycles with %0d answers outstanding",
                 LIMIT, answer_queue.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int directed_total;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        pat_len   = 0;
        pat_fault = 1'b0;
        live_pos  = {{MAX_EL{1'b0}}, 1'b1};
        dir_rows = '{
            '{dspm_pkg::OP_END,    8'h00,                   6'd1,  1'b1, 1'b1, 1'b0},
            '{dspm_pkg::OP_APPEND, dspm_pkg::STAR_BYTE,     6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_END,    8'h00,                   6'd1,  1'b1, 1'b0, 1'b1},
            '{dspm_pkg::OP_CLEAR,  8'h00,                   6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_APPEND, 8'h61,                   6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_APPEND, dspm_pkg::STAR_BYTE,     6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_APPEND, dspm_pkg::STAR_BYTE,     6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_END,    8'hFF,                   6'd1,  1'b1, 1'b0, 1'b1},
            '{dspm_pkg::OP_CLEAR,  8'hFF,                   6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_APPEND, 8'h00,                   6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_APPEND, dspm_pkg::WILDCARD_BYTE, 6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_APPEND, dspm_pkg::STAR_BYTE,     6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_APPEND, 8'hFF,                   6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_APPEND, 8'h62,                   6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_APPEND, dspm_pkg::STAR_BYTE,     6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_TEXT,   8'h00,                   6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_TEXT,   8'h55,                   6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_TEXT,   8'hFF,                   6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_END,    8'h00,                   6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_TEXT,   8'hFF,                   6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_END,    8'h00,                   6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_TEXT,   dspm_pkg::WILDCARD_BYTE, 6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_TEXT,   8'h62,                   6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_END,    8'h00,                   6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_CLEAR,  8'h00,                   6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_APPEND, 8'hFF,                   6'd32, 1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_TEXT,   8'hFF,                   6'd32, 1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_END,    8'h00,                   6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_APPEND, 8'h01,                   6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_TEXT,   8'hFF,                   6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_END,    8'h00,                   6'd1,  1'b1, 1'b0, 1'b1},
            '{dspm_pkg::OP_CLEAR,  8'h00,                   6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_TEXT,   dspm_pkg::STAR_BYTE,     6'd1,  1'b0, 1'b0, 1'b0},
            '{dspm_pkg::OP_END,    8'h00,                   6'd1,  1'b0, 1'b0, 1'b0}
        };
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            repeat (dir_rows[r].reps) begin
                send('{opcode: dir_rows[r].opcode, symbol: dir_rows[r].symbol},
                     dir_rows[r].pinned,
                     '{matched: dir_rows[r].matched, pattern_fault: dir_rows[r].fault});
            end
        end

        directed_total = items_sent;
        while (items_sent < directed_total + RANDOM_ITEMS) begin
            if (!hold_issued && items_sent > directed_total + RANDOM_ITEMS / 3) begin
                hold_request = 1'b1;
                hold_issued  = 1'b1;
            end
            no_idle = ($urandom_range(0, 5) == 0);
            random_sequence();
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (answer_queue.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (answer_queue.size() != 0) begin
            fail_count += answer_queue.size();
            $display("%0d expected answers never arrived", answer_queue.size());
        end

        $display("Sent %0d transactions, checked %0d end-of-text answers", items_sent,
                 answers_checked);
        $display("Answers with a match: %0d, with a pattern fault: %0d, failures: %0d",
                 matches_seen, faults_seen, fail_count);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
